@@ hdl/stsc_pkg.sv @@
// ============================================================================
// Time sync correction package
// Shared widths, message codes, constants and record types of the per-port
// clock correction block.
// ============================================================================
`default_nettype none

package stsc_pkg;

    // Default number of ports that keep a record.
    localparam int PORTS_DEFAULT = 8;

    // Message kinds carried on the input channel.
    localparam logic MODE_RESPONSE  = 1'b0;
    localparam logic MODE_FOLLOW_UP = 1'b1;

    // Field widths.
    localparam int TIME_W  = 64;
    localparam int WORD_W  = 32;
    localparam int MAC_W   = 48;
    localparam int PORT_W  = 3;
    localparam int SPEED_W = 19;

    // Utilization test: loaded when rate * 800 > speed * 1000000.
    // The rate side needs 32 + 10 bits; the speed side 19 + 20 bits.
    localparam int LOAD_W   = 42;
    localparam int SCALED_W = 39;

    localparam logic [LOAD_W-1:0]   RATE_SCALE  = LOAD_W'(800);
    localparam logic [SCALED_W-1:0] SPEED_SCALE = SCALED_W'(1000000);
    localparam logic [SPEED_W-1:0]  SPEED_RESET = SPEED_W'(10000);

    // One port's stored record. Only the low word of the MAC stamp matters
    // to the 32-bit wire delay, and the rate is kept already scaled.
    typedef struct packed {
        logic [TIME_W-1:0] ref_now;
        logic [LOAD_W-1:0] load_lhs;
        logic [WORD_W-1:0] mac_lo;
        logic [WORD_W-1:0] round_trip;
        logic [WORD_W-1:0] profile;
    } port_rec_t;

    // An accepted item as held in the update stage.
    typedef struct packed {
        logic              mode;
        logic [TIME_W-1:0] ref_now;
        logic [LOAD_W-1:0] load_lhs;
        logic [WORD_W-1:0] mac_lo;
        logic [WORD_W-1:0] round_trip;
        logic [WORD_W-1:0] switch_tx;
        logic [TIME_W-1:0] nic_time;
    } stsc_item_t;

    // One result of a follow-up.
    typedef struct packed {
        logic [TIME_W-1:0] corrected_now;
        logic [TIME_W-1:0] clock_offset;
        logic [WORD_W-1:0] wire_delay;
        logic [WORD_W-1:0] response_delay;
        logic [WORD_W-1:0] round_trip;
        logic              link_loaded;
        logic [WORD_W-1:0] profile_delay;
    } stsc_result_t;

endpackage

`default_nettype wire

@@ hdl/stsc_ram.sv @@
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// A read and a write to the same address in the same cycle return the old data.
// ============================================================================
`default_nettype none

module stsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                   aclk,
    input  wire logic                                   wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic                                   rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/stsc_calc.sv @@
// ============================================================================
// Time sync record update
// Computes the follow-up result and the record to write back for the item
// in the update stage, given the port's current record.
// ============================================================================
`default_nettype none

module stsc_calc
    import stsc_pkg::*;
(
    input  wire stsc_item_t                item,
    input  wire port_rec_t                 old_rec,
    input  wire logic [SCALED_W-1:0]       speed_scaled,
    output port_rec_t                      new_rec,
    output stsc_result_t                   result
);

    logic [WORD_W-1:0] wire_u;
    logic [WORD_W-1:0] wire_adj;
    logic [WORD_W-1:0] resp_u;
    logic [WORD_W-1:0] prof_sum;
    logic [WORD_W-1:0] prof_new;
    logic [TIME_W-1:0] corrected;
    logic              loaded;
    logic              light;

    always_comb begin
        // Round trip minus switch residence (switch tx minus MAC ingress).
        wire_u = old_rec.round_trip + old_rec.mac_lo - item.switch_tx;

        loaded = {{(LOAD_W - SCALED_W){1'b0}}, speed_scaled} < old_rec.load_lhs;
        light  = old_rec.load_lhs < {{(LOAD_W - SCALED_W){1'b0}}, speed_scaled};

        // Signed halving that truncates toward zero.
        wire_adj = wire_u + {{(WORD_W - 1){1'b0}}, wire_u[WORD_W-1]};

        if (loaded) begin
            resp_u = {1'b0, old_rec.profile[WORD_W-1:1]};
        end else begin
            resp_u = {wire_adj[WORD_W-1], wire_adj[WORD_W-1:1]};
        end

        corrected = old_rec.ref_now + {{(TIME_W - WORD_W){resp_u[WORD_W-1]}}, resp_u};

        prof_sum = old_rec.profile + wire_u;
        if (!light) begin
            prof_new = old_rec.profile;
        end else if (old_rec.profile != '0) begin
            prof_new = {1'b0, prof_sum[WORD_W-1:1]};
        end else begin
            prof_new = wire_u;
        end

        if (item.mode == MODE_FOLLOW_UP) begin
            new_rec         = old_rec;
            new_rec.ref_now = corrected;
            new_rec.profile = prof_new;
        end else begin
            new_rec.ref_now    = item.ref_now;
            new_rec.load_lhs   = item.load_lhs;
            new_rec.mac_lo     = item.mac_lo;
            new_rec.round_trip = item.round_trip;
            new_rec.profile    = old_rec.profile;
        end

        result.corrected_now  = corrected;
        result.clock_offset   = corrected - item.nic_time;
        result.wire_delay     = wire_u;
        result.response_delay = resp_u;
        result.round_trip     = old_rec.round_trip;
        result.link_loaded    = loaded;
        result.profile_delay  = prof_new;
    end

endmodule

`default_nettype wire

@@ hdl/switch_time_sync_correction.sv @@
// ============================================================================
// Switch time sync correction
// Per-port clock correction: responses store the switch reference time and
// link figures of a port, follow-ups turn them into a corrected time, a
// clock offset and an updated profiled wire delay.
// ============================================================================
//
//  Channel   Direction  Transfer carries
//  --------  ---------  ------------------------------------------------------
//  s_*       in         response or follow-up message for one port
//  m_*       out        corrected time and offset, one per follow-up
//  cfg_*     in         link speed in Mbit/s (single register, write only)
//
// A transfer is accepted and its record is read from the port RAM; the update
// stage updates it and, when it moves on, writes it back and, for a follow-up,
// loads the output register. A new transfer can be accepted every cycle while
// the output does not stall; a back-to-back access to the same port takes the
// record from a forwarding register instead of the RAM. Responses produce no
// output and never wait on m_tready. Reset clears a valid bit per port, so
// every record reads as zero until written; no clearing pass is needed. A
// stalled output holds one follow-up in the update stage and drops s_tready.
// ============================================================================
`default_nettype none

module switch_time_sync_correction
    import stsc_pkg::*;
#(
    parameter int PORTS = PORTS_DEFAULT
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,

    input  wire logic           cfg_wr_en,
    input  wire logic [18:0]    cfg_wr_data,    // link_speed_mbps

    input  wire logic           s_tvalid,
    output logic                s_tready,
    // reference_now[63:0], port_rate_bytes[95:64], ingress_mac_ts[143:96],
    // request_tx_time[207:144], response_rx_time[271:208],
    // switch_tx_ts[303:272], nic_time[367:304]
    input  wire logic [367:0]   s_tdata,
    // mode[0], port[3:1]
    input  wire logic [3:0]     s_tuser,

    output logic                m_tvalid,
    input  wire logic           m_tready,
    // corrected_now[63:0], clock_offset[127:64], wire_delay[159:128],
    // response_delay[191:160], round_trip[223:192], profile_delay[255:224]
    output logic [255:0]        m_tdata,
    // link_loaded[0]
    output logic [0:0]          m_tuser
);

    localparam int        AW      = (PORTS > 1) ? $clog2(PORTS) : 1;
    localparam int        REC_W   = $bits(port_rec_t);
    localparam logic [6:0] PORTS_N = 7'(PORTS);
    localparam logic [SCALED_W-1:0] SPEED_SCALED_RESET =
        SCALED_W'({{(SCALED_W - SPEED_W){1'b0}}, SPEED_RESET} * SPEED_SCALE);

    // Input field views.
    logic              in_mode;
    logic [PORT_W-1:0] in_port;
    logic [AW-1:0]     in_addr;
    logic              in_port_ok;
    logic              accept;

    assign in_mode    = s_tuser[0];
    assign in_port    = s_tuser[3:1];
    assign in_addr    = AW'(in_port);
    assign in_port_ok = {4'd0, in_port} < PORTS_N;
    assign accept     = s_tvalid && s_tready;

    // The speed side of the utilization test is scaled once, at the write.
    logic [SCALED_W-1:0] speed_scaled_reg;
    logic [SCALED_W-1:0] speed_scaled_next;

    always_comb begin
        speed_scaled_next = speed_scaled_reg;
        if (cfg_wr_en) begin
            speed_scaled_next =
                {{(SCALED_W - SPEED_W){1'b0}}, cfg_wr_data} * SPEED_SCALE;
        end
    end

    // Update stage: the accepted item, prepared at the accept edge.
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [AW-1:0]     s1_addr_reg;
    stsc_item_t        s1_item_reg;
    stsc_item_t        s1_item_next;
    logic              s1_adv;

    // Forwarding and record validity for the item in the update stage.
    logic              fwd_hit_reg;
    logic              fwd_hit_next;
    logic              rd_valid_reg;
    logic              rd_valid_next;
    port_rec_t         fwd_rec_reg;
    logic [PORTS-1:0]  valid_reg;
    logic [PORTS-1:0]  valid_next;

    // Output register.
    logic              m_valid_reg;
    logic              m_valid_next;
    stsc_result_t      m_result_reg;

    // Record path.
    logic [REC_W-1:0]  ram_rd_data;
    port_rec_t         old_rec;
    port_rec_t         new_rec;
    stsc_result_t      result;
    logic              out_load;

    // A response always moves on; a follow-up moves on when the output
    // register is free or is being emptied in this cycle.
    assign s1_adv   = s1_valid_reg
                      && ((s1_item_reg.mode == MODE_RESPONSE) || !m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign out_load = s1_adv && (s1_item_reg.mode == MODE_FOLLOW_UP);

    always_comb begin
        // The round trip and the scaled rate are formed on the way in, so the
        // update stage sees them only in the form that it stores.
        s1_item_next.mode       = in_mode;
        s1_item_next.ref_now    = s_tdata[63:0];
        s1_item_next.load_lhs   = {{(LOAD_W - WORD_W){1'b0}}, s_tdata[95:64]} * RATE_SCALE;
        s1_item_next.mac_lo     = s_tdata[127:96];
        s1_item_next.round_trip = s_tdata[239:208] - s_tdata[175:144];
        s1_item_next.switch_tx  = s_tdata[303:272];
        s1_item_next.nic_time   = s_tdata[367:304];
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            // A port outside the record table is dropped here.
            s1_valid_next = in_port_ok;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end

        fwd_hit_next  = fwd_hit_reg;
        rd_valid_next = rd_valid_reg;
        if (accept) begin
            // The write in this same cycle is not yet visible in the RAM read.
            fwd_hit_next  = s1_adv && (s1_addr_reg == in_addr);
            rd_valid_next = in_port_ok && valid_reg[in_addr];
        end

        valid_next = valid_reg;
        if (s1_adv) begin
            valid_next[s1_addr_reg] = 1'b1;
        end

        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_scaled_reg <= SPEED_SCALED_RESET;
            s1_valid_reg     <= 1'b0;
            fwd_hit_reg      <= 1'b0;
            rd_valid_reg     <= 1'b0;
            valid_reg        <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            speed_scaled_reg <= speed_scaled_next;
            s1_valid_reg     <= s1_valid_next;
            fwd_hit_reg      <= fwd_hit_next;
            rd_valid_reg     <= rd_valid_next;
            valid_reg        <= valid_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_addr_reg <= in_addr;
            s1_item_reg <= s1_item_next;
        end
        if (s1_adv) begin
            fwd_rec_reg <= new_rec;
        end
        if (out_load) begin
            m_result_reg <= result;
        end
    end

    // Per-port records. Read at the accept edge, written when the update
    // stage moves on.
    stsc_ram #(
        .WIDTH (REC_W),
        .DEPTH (PORTS)
    ) u_rec_ram (
        .aclk    (aclk),
        .wr_en   (s1_adv),
        .wr_addr (s1_addr_reg),
        .wr_data (new_rec),
        .rd_en   (accept),
        .rd_addr (in_addr),
        .rd_data (ram_rd_data)
    );

    // A record never written reads as all zeros.
    always_comb begin
        if (fwd_hit_reg) begin
            old_rec = fwd_rec_reg;
        end else if (rd_valid_reg) begin
            old_rec = port_rec_t'(ram_rd_data);
        end else begin
            old_rec = '0;
        end
    end

    stsc_calc u_calc (
        .item         (s1_item_reg),
        .old_rec      (old_rec),
        .speed_scaled (speed_scaled_reg),
        .new_rec      (new_rec),
        .result       (result)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_result_reg.profile_delay,
                       m_result_reg.round_trip,
                       m_result_reg.response_delay,
                       m_result_reg.wire_delay,
                       m_result_reg.clock_offset,
                       m_result_reg.corrected_now};
    assign m_tuser  = m_result_reg.link_loaded;

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// ============================================================================
// Time sync correction testbench
// Drives response and follow-up transfers into the per-port clock correction
// block, predicts every corrected time, offset, wire delay, response delay
// and profiled delay in a behavioral copy of the block, and compares each
// output transfer field by field. The run steps through several link speeds
// and several patterns of sender gaps and receiver back-pressure.
// ============================================================================
`default_nettype none

module tb_top;
    import stsc_pkg::*;

    // ------------------------------------------------------------------------
    // Run constants
    // ------------------------------------------------------------------------
    localparam int NUM_PORTS      = PORTS_DEFAULT;
    localparam int PHASE_ITEMS    = 116;   // random transfers per phase
    localparam int RANDOM_PHASES  = 8;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 4000;  // cycles without any transfer
    localparam int PRINT_LIMIT    = 200;   // mismatch lines printed at most

    // One input message as queued for the driver.
    typedef struct {
        logic        mode;
        logic [2:0]  port;
        logic [63:0] ref_now;
        logic [31:0] rate;
        logic [47:0] mac_ts;
        logic [63:0] req_tx;
        logic [63:0] rsp_rx;
        logic [31:0] sw_tx;
        logic [63:0] nic_time;
    } sync_msg_t;

    // One output transfer of a follow-up.
    typedef struct {
        logic [63:0] corrected;
        logic [63:0] offset;
        logic [31:0] wire_dly;
        logic [31:0] resp_dly;
        logic [31:0] rtt;
        logic        loaded;
        logic [31:0] profile;
    } correction_t;

    // ------------------------------------------------------------------------
    // Clock, reset and the block's inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic         aclk        = 1'b0;
    logic         aresetn     = 1'b0;
    logic         cfg_wr_en   = 1'b0;
    logic [18:0]  cfg_wr_data = '0;
    logic         s_tvalid    = 1'b0;
    logic [367:0] s_tdata     = '0;
    logic [3:0]   s_tuser     = '0;
    logic         m_tready    = 1'b0;

    wire logic         s_tready;
    wire logic         m_tvalid;
    wire logic [255:0] m_tdata;
    wire logic [0:0]   m_tuser;

    always #4 aclk = ~aclk;

    switch_time_sync_correction DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // ------------------------------------------------------------------------
    // Testbench state
    // ------------------------------------------------------------------------
    sync_msg_t   pending_msgs[$];          // messages not yet offered
    correction_t expected_corrections[$];  // predicted output transfers

    // Behavioral copy of the per-port records and the speed register.
    logic [63:0] port_ref_now [NUM_PORTS];
    logic [31:0] port_rate    [NUM_PORTS];
    logic [47:0] port_mac     [NUM_PORTS];
    logic [31:0] port_rtt     [NUM_PORTS];
    logic [31:0] port_profile [NUM_PORTS];
    logic [18:0] model_speed;

    int   s_idle_pct  = 0;   // chance in percent that the sender idles a cycle
    int   m_stall_pct = 0;   // chance in percent that the receiver stalls
    logic s_fire      = 1'b0;

    int mismatches     = 0;
    int printed_lines  = 0;
    int idle_cycles    = 0;
    int n_responses    = 0;
    int n_follow_ups   = 0;
    int n_checked      = 0;
    int n_loaded       = 0;
    int n_speeds       = 1;

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // ------------------------------------------------------------------------
    // Predictor: applies one accepted message to the record copy and, for a
    // follow-up, queues the output transfer it must cause.
    // ------------------------------------------------------------------------
    task automatic predict_correction(input sync_msg_t msg);
        int                 p;
        logic [31:0]        wire_u;
        logic [31:0]        prof;
        logic [31:0]        sum;
        logic signed [31:0] wire_s;
        logic signed [63:0] resp_s;
        logic [63:0]        lhs;
        logic [63:0]        rhs;
        logic [63:0]        corrected;
        logic               is_loaded;
        logic               is_light;
        correction_t        c;
        p = msg.port;
        if (msg.mode == MODE_RESPONSE) begin
            port_ref_now[p] = msg.ref_now;
            port_rate[p]    = msg.rate;
            port_mac[p]     = msg.mac_ts;
            // Only the low word of the round trip is kept.
            port_rtt[p]     = msg.rsp_rx[31:0] - msg.req_tx[31:0];
            n_responses++;
            return;
        end
        // Wire delay: round trip minus the residence time inside the switch.
        wire_u = port_rtt[p] - (msg.sw_tx - port_mac[p][31:0]);
        wire_s = wire_u;
        // Exact utilization test: loaded above one percent of the link speed.
        lhs       = 64'(port_rate[p]) * 64'd800;
        rhs       = 64'(model_speed) * 64'd1000000;
        is_loaded = lhs > rhs;
        is_light  = lhs < rhs;
        prof      = port_profile[p];
        if (is_loaded) begin
            resp_s = {32'd0, prof >> 1};
        end else begin
            resp_s = wire_s / 2;   // truncates toward zero
        end
        corrected       = port_ref_now[p] + resp_s;
        port_ref_now[p] = corrected;
        if (is_light) begin
            if (prof != 0) begin
                sum  = prof + wire_u;
                prof = sum >> 1;
            end else begin
                prof = wire_u;
            end
            port_profile[p] = prof;
        end
        c.corrected = corrected;
        c.offset    = corrected - msg.nic_time;
        c.wire_dly  = wire_u;
        c.resp_dly  = resp_s[31:0];
        c.rtt       = port_rtt[p];
        c.loaded    = is_loaded;
        c.profile   = prof;
        expected_corrections.push_back(c);
        n_follow_ups++;
    endtask

    task automatic report_field(input string fname, input logic [63:0] exp_v,
                                input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            mismatches++;
            if (printed_lines < PRINT_LIMIT) begin
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                         $time, fname, exp_v, act_v);
                printed_lines++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: changes the input channel and m_tready at the falling edge.
    // A message stays on the bus until a transfer takes it.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        sync_msg_t msg;
        if (!s_tvalid || s_fire) begin
            if (pending_msgs.size() != 0 && $urandom_range(0, 99) >= s_idle_pct) begin
                msg      = pending_msgs.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {msg.nic_time, msg.sw_tx, msg.rsp_rx, msg.req_tx,
                             msg.mac_ts, msg.rate, msg.ref_now};
                s_tuser  <= {msg.port, msg.mode};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= ($urandom_range(0, 99) >= m_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Monitor: samples both channels and the register write at the rising
    // edge. The output check comes before the prediction, so a result can
    // never be matched against the message accepted at the same edge.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        sync_msg_t   msg;
        correction_t exp_c;
        correction_t act_c;
        s_fire <= s_tvalid && s_tready;
        if (!aresetn) begin
            for (int i = 0; i < NUM_PORTS; i++) begin
                port_ref_now[i] = '0;
                port_rate[i]    = '0;
                port_mac[i]     = '0;
                port_rtt[i]     = '0;
                port_profile[i] = '0;
            end
            model_speed = SPEED_RESET;
        end else begin
            if (m_tvalid && m_tready) begin
                act_c.corrected = m_tdata[63:0];
                act_c.offset    = m_tdata[127:64];
                act_c.wire_dly  = m_tdata[159:128];
                act_c.resp_dly  = m_tdata[191:160];
                act_c.rtt       = m_tdata[223:192];
                act_c.profile   = m_tdata[255:224];
                act_c.loaded    = m_tuser[0];
                if (expected_corrections.size() == 0) begin
                    mismatches++;
                    $display("%0t: output transfer with nothing expected, corrected_now 0x%0h",
                             $time, act_c.corrected);
                end else begin
                    exp_c = expected_corrections.pop_front();
                    report_field("corrected_now", exp_c.corrected, act_c.corrected);
                    report_field("clock_offset", exp_c.offset, act_c.offset);
                    report_field("wire_delay", exp_c.wire_dly, act_c.wire_dly);
                    report_field("response_delay", exp_c.resp_dly, act_c.resp_dly);
                    report_field("round_trip", exp_c.rtt, act_c.rtt);
                    report_field("link_loaded", exp_c.loaded, act_c.loaded);
                    report_field("profile_delay", exp_c.profile, act_c.profile);
                    n_checked++;
                    if (exp_c.loaded) n_loaded++;
                end
            end
            if (s_tvalid && s_tready) begin
                msg.mode     = s_tuser[0];
                msg.port     = s_tuser[3:1];
                msg.ref_now  = s_tdata[63:0];
                msg.rate     = s_tdata[95:64];
                msg.mac_ts   = s_tdata[143:96];
                msg.req_tx   = s_tdata[207:144];
                msg.rsp_rx   = s_tdata[271:208];
                msg.sw_tx    = s_tdata[303:272];
                msg.nic_time = s_tdata[367:304];
                predict_correction(msg);
            end
            // Writes only happen while the block is idle.
            if (cfg_wr_en) model_speed = cfg_wr_data;

            // Watchdog on cycles in which no transfer happens on either side.
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
                    $display("tb_top failed");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers. Fields that a message kind ignores still get random
    // values so that every bit of every field toggles.
    // ------------------------------------------------------------------------
    task automatic queue_response(input logic [2:0] p, input logic [63:0] ref_now,
                                  input logic [31:0] rate, input logic [47:0] mac_ts,
                                  input logic [63:0] req_tx, input logic [63:0] rsp_rx);
        sync_msg_t msg;
        msg.mode     = MODE_RESPONSE;
        msg.port     = p;
        msg.ref_now  = ref_now;
        msg.rate     = rate;
        msg.mac_ts   = mac_ts;
        msg.req_tx   = req_tx;
        msg.rsp_rx   = rsp_rx;
        msg.sw_tx    = $urandom();
        msg.nic_time = rand64();
        pending_msgs.push_back(msg);
    endtask

    task automatic queue_follow_up(input logic [2:0] p, input logic [31:0] sw_tx,
                                   input logic [63:0] nic_time);
        sync_msg_t msg;
        msg.mode     = MODE_FOLLOW_UP;
        msg.port     = p;
        msg.ref_now  = rand64();
        msg.rate     = $urandom();
        msg.mac_ts   = rand64();
        msg.req_tx   = rand64();
        msg.rsp_rx   = rand64();
        msg.sw_tx    = sw_tx;
        msg.nic_time = nic_time;
        pending_msgs.push_back(msg);
    endtask

    // Port rates cluster around the one percent threshold of the speed.
    function automatic logic [31:0] pick_rate(input logic [18:0] speed);
        logic [31:0] edge_rate;
        edge_rate = 32'(speed) * 32'd1250;
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return $urandom();
            2:       return edge_rate;
            3:       return edge_rate + 32'd1;
            4:       return edge_rate - 32'd1;
            5:       return '1;
            default: return $urandom_range(0, edge_rate);
        endcase
    endfunction

    // Mostly well-formed response and follow-up pairs with realistic stamps,
    // the rest lone messages with fully random content.
    task automatic queue_random_phase(input int target, input logic [18:0] speed);
        int          start;
        logic [2:0]  p;
        logic [63:0] ref_now;
        logic [63:0] req_tx;
        logic [47:0] mac_ts;
        logic [31:0] rtt;
        logic [31:0] residence;
        int          kind;
        start = pending_msgs.size();
        while (pending_msgs.size() - start < target) begin
            kind = $urandom_range(0, 99);
            p    = $urandom_range(0, NUM_PORTS - 1);
            if (kind < 70) begin
                ref_now = ($urandom_range(0, 9) == 0) ? ~64'($urandom_range(0, 5000))
                                                     : rand64();
                req_tx    = rand64();
                rtt       = $urandom_range(100, 200000);
                mac_ts    = rand64();
                residence = $urandom_range(0, rtt + 1000);
                queue_response(p, ref_now, pick_rate(speed), mac_ts, req_tx,
                               req_tx + rtt);
                if ($urandom_range(0, 3) == 0) begin
                    queue_response(3'(p + $urandom_range(1, NUM_PORTS - 1)), rand64(),
                                   pick_rate(speed), rand64(), rand64(), rand64());
                end
                queue_follow_up(p, mac_ts[31:0] + residence,
                                ref_now + 64'($signed($urandom_range(0, 2000000)) - 1000000));
                // A repeated follow-up adds its delay to the kept time again.
                if ($urandom_range(0, 4) == 0) begin
                    queue_follow_up(p, mac_ts[31:0] + $urandom_range(0, rtt), rand64());
                end
            end else if (kind < 85) begin
                queue_follow_up(p, $urandom(), rand64());
            end else begin
                queue_response(p, rand64(), pick_rate(speed), rand64(), rand64(), rand64());
            end
        end
    endtask

    // Waits until every message is taken and every result has arrived, then
    // lets a response still in the update stage finish.
    task automatic wait_until_idle();
        while (pending_msgs.size() != 0 || s_tvalid || expected_corrections.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_link_speed(input logic [18:0] speed);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= speed;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        @(posedge aclk);
        n_speeds++;
    endtask

    // ------------------------------------------------------------------------
    // Sequencer: reset, a directed phase at the reset speed, then random
    // phases that each pick a speed and a pattern of gaps and stalls.
    // ------------------------------------------------------------------------
    initial begin
        logic [18:0] speed;
        int          idle_kind;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed phase, link speed 10000 Mbit/s, no gaps or stalls.
        // All-zero record, then a follow-up on it.
        queue_response(3'd0, '0, '0, '0, '0, '0);
        queue_follow_up(3'd0, '0, '0);
        // All-ones record: loaded and not yet profiled, so no delay is added.
        queue_response(3'd7, '1, '1, '1, '0, '1);
        queue_follow_up(3'd7, '0, '1);
        queue_follow_up(3'd7, '1, '0);
        // Utilization of exactly one percent: half the wire delay, no profiling.
        queue_response(3'd1, 64'd5000000, 32'd12500000, 48'd5000, 64'd7000, 64'd8000);
        queue_follow_up(3'd1, 32'd5200, 64'd5000300);
        // Light load: the first follow-up seeds the profile, the second one
        // averages it and adds its delay to the kept time again.
        queue_response(3'd2, 64'd1000, 32'd1, 48'd100, 64'd10, 64'd3011);
        queue_follow_up(3'd2, 32'd100, 64'd900);
        queue_follow_up(3'd2, 32'd100, 64'd4000);
        // Negative wire delay: odd halving truncates toward zero.
        queue_response(3'd2, 64'd2000, 32'd1, 48'h0, 64'd500, 64'd600);
        queue_follow_up(3'd2, 32'd1001, 64'd2100);
        // Loaded with a profile in place: half the profile is used.
        queue_response(3'd2, 64'd3000, 32'd12500001, 48'd0, 64'd0, 64'd50);
        queue_follow_up(3'd2, 32'd10, 64'd2900);
        // Profile average whose sum wraps past 32 bits.
        queue_response(3'd3, 64'd77, 32'd0, 48'hABCD_1234_5678, 64'd0, 64'h8000_0001);
        queue_follow_up(3'd3, 32'h1234_5678, 64'd0);
        queue_follow_up(3'd3, 32'h1234_5678, 64'd0);
        // Corrected time wrapping past 64 bits.
        queue_response(3'd5, 64'hFFFF_FFFF_FFFF_FFF0, 32'd0, 48'd40, 64'd0, 64'd100);
        queue_follow_up(3'd5, 32'd40, 64'd0);
        // Follow-up on a port that never saw a response.
        queue_follow_up(3'd4, 32'hFFFF_FFFF, rand64());
        // Fully random pair.
        queue_response(3'd6, rand64(), $urandom(), rand64(), rand64(), rand64());
        queue_follow_up(3'd6, $urandom(), rand64());
        wait_until_idle();

        // Random phases. Speed zero and both range extremes are among them.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0:       speed = 19'd1;
                1:       speed = 19'd400000;
                2:       speed = 19'd0;
                4:       speed = 19'd10000;
                5:       speed = 19'd400000;
                6:       speed = 19'd1;
                default: speed = $urandom_range(1, 400000);
            endcase
            idle_kind = ph % 4;
            s_idle_pct  = (idle_kind == 1) ? 71 : (idle_kind == 3) ? 13 : 0;
            m_stall_pct = (idle_kind == 2) ? 71 : (idle_kind == 3) ? 13 : 0;
            write_link_speed(speed);
            queue_random_phase(PHASE_ITEMS, speed);
            wait_until_idle();
        end

        if (expected_corrections.size() != 0) begin
            mismatches++;
            $display("%0t: %0d expected output transfers never arrived",
                     $time, expected_corrections.size());
        end
        $display("Covered %0d responses and %0d follow-ups under %0d link speed settings.",
                 n_responses, n_follow_ups, n_speeds);
        $display("Checked %0d corrections, %0d of them on a loaded link; %0d mismatches.",
                 n_checked, n_loaded, mismatches);
        if (mismatches == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
hdl/stsc_pkg.sv
hdl/stsc_ram.sv
hdl/stsc_calc.sv
hdl/switch_time_sync_correction.sv
sim/tb_top.sv
